[rtl/lrvsp_pkg.sv]
`default_nettype none

package lrvsp_pkg;

    localparam int LOOP_DEPTH_DEF = 65536;
    localparam int FRAC_BITS_DEF  = 12;

    localparam int FUNC_W   = 2;
    localparam int SAMPLE_W = 16;
    localparam int SPEED_W  = 16;

    localparam logic [SPEED_W-1:0] SPEED_RESET = 16'd4096;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_START = 2'd0,
        FUNC_REC   = 2'd1,
        FUNC_STOP  = 2'd2,
        FUNC_PLAY  = 2'd3
    } t_func;

    typedef struct packed {
        logic latch;
        logic start;
        logic rec_write;
        logic reject;
        logic stop;
        logic rd_cur;
        logic rd_nxt;
        logic mul;
        logic wrap_sub;
        logic load;
    } t_cmd;

    typedef struct packed {
        t_func func;
        logic  rec;
        logic  ready;
        logic  count_lt_depth;
        logic  phase_ge_span;
    } t_stat;

endpackage

`default_nettype wire

[rtl/loop_recorder_variable_speed_player.sv]
`default_nettype none

// Loop recorder with variable-speed playback. Each input item carries a
// command (start record, record one sample, stop record, play one sample)
// and produces exactly one result item with the played sample and the loop
// status after the command. Start, record, stop and a play on a loop that is
// not ready go from decode straight to the done state. A play first has the
// single read port of the loop memory fetch the two neighboring entries one
// after the other, then the multiply state forms the interpolation product,
// and the phase wrap subtracts the loop span once per cycle as often as
// needed (never unless the advanced phase passes the loop end, at most 10
// times for a one-sample loop at the top speed). The result sits in an
// output register, so a stalled result does not hold up the next item until
// that item's own result is due. The speed register resets to 1.0 at the
// default FRAC_BITS; write it only while no item is in flight.

module loop_recorder_variable_speed_player #(
    parameter int LOOP_DEPTH = lrvsp_pkg::LOOP_DEPTH_DEF,
    parameter int FRAC_BITS  = lrvsp_pkg::FRAC_BITS_DEF
) (
    input  wire                                     i_clk,
    input  wire                                     i_rst_n,
    input  wire                                     i_in_valid,
    output logic                                    o_in_stall,
    input  wire  [lrvsp_pkg::FUNC_W-1:0]            i_func,
    input  wire  signed [lrvsp_pkg::SAMPLE_W-1:0]   i_sample_in,
    output logic                                    o_out_valid,
    input  wire                                     i_out_stall,
    output logic signed [lrvsp_pkg::SAMPLE_W-1:0]   o_sample_out,
    output logic                                    o_played,
    output logic                                    o_rejected,
    output logic [$clog2(LOOP_DEPTH):0]             o_loop_length,
    output logic                                    o_loop_armed,
    output logic                                    o_recording_active,
    input  wire                                     i_cfg_valid,
    output logic                                    o_cfg_ready,
    input  wire  [lrvsp_pkg::SPEED_W-1:0]           i_cfg_data
);
    import lrvsp_pkg::*;

    localparam int CW = $clog2(LOOP_DEPTH) + 1;

    t_cmd  cmd;
    t_stat stat;

    assign o_cfg_ready = 1'b1;

    lrvsp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    lrvsp_dp #(
        .LOOP_DEPTH (LOOP_DEPTH),
        .FRAC_BITS  (FRAC_BITS),
        .CW         (CW)
    ) u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_func             (i_func),
        .i_sample_in        (i_sample_in),
        .i_cfg_we           (i_cfg_valid && o_cfg_ready),
        .i_cfg_data         (i_cfg_data),
        .i_cmd              (cmd),
        .o_stat             (stat),
        .o_sample_out       (o_sample_out),
        .o_played           (o_played),
        .o_rejected         (o_rejected),
        .o_loop_length      (o_loop_length),
        .o_loop_armed       (o_loop_armed),
        .o_recording_active (o_recording_active)
    );

endmodule

`default_nettype wire

[rtl/lrvsp_ctrl.sv]
`default_nettype none

module lrvsp_ctrl (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_in_valid,
    output logic              o_in_stall,
    output logic              o_out_valid,
    input  wire               i_out_stall,
    input  lrvsp_pkg::t_stat  i_stat,
    output lrvsp_pkg::t_cmd   o_cmd
);
    import lrvsp_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_DECODE = 6'b000010,
        S_RD_NXT = 6'b000100,
        S_MUL    = 6'b001000,
        S_WRAP   = 6'b010000,
        S_DONE   = 6'b100000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   out_free;

    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_out_valid = r_out_valid;
    assign o_in_stall  = (r_state != S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.latch = 1'b1;
                    n_state     = S_DECODE;
                end
            end
            S_DECODE: begin
                n_state = S_DONE;
                unique case (i_stat.func)
                    FUNC_START: o_cmd.start = 1'b1;
                    FUNC_REC: begin
                        if (i_stat.rec && i_stat.count_lt_depth) begin
                            o_cmd.rec_write = 1'b1;
                        end else begin
                            o_cmd.reject = 1'b1;
                        end
                    end
                    FUNC_STOP: o_cmd.stop = i_stat.rec;
                    FUNC_PLAY: begin
                        if (i_stat.ready) begin
                            o_cmd.rd_cur = 1'b1;
                            n_state      = S_RD_NXT;
                        end
                    end
                    default: n_state = S_DONE;
                endcase
            end
            S_RD_NXT: begin
                o_cmd.rd_nxt = 1'b1;
                n_state      = S_MUL;
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_WRAP;
            end
            S_WRAP: begin
                if (i_stat.phase_ge_span) begin
                    o_cmd.wrap_sub = 1'b1;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.load) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

`default_nettype wire

[rtl/lrvsp_dp.sv]
`default_nettype none

module lrvsp_dp #(
    parameter int LOOP_DEPTH = lrvsp_pkg::LOOP_DEPTH_DEF,
    parameter int FRAC_BITS  = lrvsp_pkg::FRAC_BITS_DEF,
    parameter int CW         = $clog2(LOOP_DEPTH) + 1
) (
    input  wire                                      i_clk,
    input  wire                                      i_rst_n,
    input  wire  [lrvsp_pkg::FUNC_W-1:0]             i_func,
    input  wire  signed [lrvsp_pkg::SAMPLE_W-1:0]    i_sample_in,
    input  wire                                      i_cfg_we,
    input  wire  [lrvsp_pkg::SPEED_W-1:0]            i_cfg_data,
    input  lrvsp_pkg::t_cmd                          i_cmd,
    output lrvsp_pkg::t_stat                         o_stat,
    output logic signed [lrvsp_pkg::SAMPLE_W-1:0]    o_sample_out,
    output logic                                     o_played,
    output logic                                     o_rejected,
    output logic [CW-1:0]                            o_loop_length,
    output logic                                     o_loop_armed,
    output logic                                     o_recording_active
);
    import lrvsp_pkg::*;

    localparam int AW   = CW - 1;
    localparam int PW   = CW + FRAC_BITS + 1;
    localparam int EW   = (FRAC_BITS + 5 > SPEED_W) ? FRAC_BITS + 5 : SPEED_W;
    localparam int PRW  = SAMPLE_W + FRAC_BITS + 2;
    localparam int RND  = 1 << (FRAC_BITS - 1);

    logic signed [SAMPLE_W-1:0] mem [LOOP_DEPTH];

    t_func                     r_func;
    logic signed [SAMPLE_W-1:0] r_sample;
    logic [SPEED_W-1:0]        r_speed;
    logic [CW-1:0]             r_count;
    logic [PW-1:0]             r_phase;
    logic                      r_ready;
    logic                      r_rec;
    logic signed [SAMPLE_W-1:0] r_rd_data;
    logic signed [SAMPLE_W-1:0] r_cur;
    logic signed [PRW-1:0]     r_prod;
    logic                      r_played;
    logic                      r_rejected;

    logic [AW-1:0]             idx;
    logic [CW-1:0]             idx_inc;
    logic [AW-1:0]             nxt;
    logic [AW-1:0]             rd_addr;
    logic [FRAC_BITS-1:0]      frac;
    logic [PW-1:0]             span;
    logic [EW-1:0]             spd_ext;
    logic [EW-1:0]             spd_eff;
    logic signed [SAMPLE_W:0]  diff;
    logic signed [PRW-1:0]     prod_rnd;
    logic signed [PRW-1:0]     q_full;
    logic signed [SAMPLE_W+1:0] res_sum;
    logic signed [SAMPLE_W-1:0] res;

    assign idx     = r_phase[FRAC_BITS +: AW];
    assign frac    = r_phase[FRAC_BITS-1:0];
    assign idx_inc = {1'b0, idx} + CW'(1);
    assign nxt     = (idx_inc < r_count) ? idx_inc[AW-1:0] : '0;
    assign rd_addr = i_cmd.rd_nxt ? nxt : idx;
    assign span    = {1'b0, r_count, {FRAC_BITS{1'b0}}};

    assign spd_ext = EW'(r_speed);
    assign spd_eff = (spd_ext == '0 || spd_ext > (EW'(10) << FRAC_BITS))
                     ? (EW'(1) << FRAC_BITS) : spd_ext;

    assign diff     = {r_rd_data[SAMPLE_W-1], r_rd_data} - {r_cur[SAMPLE_W-1], r_cur};
    assign prod_rnd = r_prod + PRW'(RND);
    assign q_full   = prod_rnd >>> FRAC_BITS;
    assign res_sum  = {{2{r_cur[SAMPLE_W-1]}}, r_cur} + {q_full[SAMPLE_W], q_full[SAMPLE_W:0]};

    always_comb begin
        res = res_sum[SAMPLE_W-1:0];
        if (!res_sum[SAMPLE_W+1] && res_sum[SAMPLE_W:SAMPLE_W-1] != 2'b00) begin
            res = {1'b0, {(SAMPLE_W-1){1'b1}}};
        end else if (res_sum[SAMPLE_W+1] && res_sum[SAMPLE_W:SAMPLE_W-1] != 2'b11) begin
            res = {1'b1, {(SAMPLE_W-1){1'b0}}};
        end
    end

    assign o_stat.func           = r_func;
    assign o_stat.rec            = r_rec;
    assign o_stat.ready          = r_ready;
    assign o_stat.count_lt_depth = (r_count < CW'(LOOP_DEPTH));
    assign o_stat.phase_ge_span  = (r_phase >= span);

    always_ff @(posedge i_clk) begin
        if (i_cmd.rec_write) begin
            mem[r_count[AW-1:0]] <= r_sample;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_cur || i_cmd.rd_nxt) begin
            r_rd_data <= mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_func   <= t_func'(i_func);
            r_sample <= i_sample_in;
        end
        if (i_cmd.rd_nxt) begin
            r_cur <= r_rd_data;
        end
        if (i_cmd.mul) begin
            r_prod <= PRW'(diff) * PRW'($signed({1'b0, frac}));
        end
        if (i_cmd.load) begin
            o_sample_out       <= r_played ? res : '0;
            o_played           <= r_played;
            o_rejected         <= r_rejected;
            o_loop_length      <= r_count;
            o_loop_armed       <= r_ready;
            o_recording_active <= r_rec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_speed    <= SPEED_RESET;
            r_count    <= '0;
            r_phase    <= '0;
            r_ready    <= 1'b0;
            r_rec      <= 1'b0;
            r_played   <= 1'b0;
            r_rejected <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_speed <= i_cfg_data;
            end
            if (i_cmd.latch) begin
                r_played   <= 1'b0;
                r_rejected <= 1'b0;
            end
            if (i_cmd.start) begin
                r_count <= '0;
                r_phase <= '0;
                r_ready <= 1'b0;
                r_rec   <= 1'b1;
            end
            if (i_cmd.rec_write) begin
                r_count <= r_count + CW'(1);
            end
            if (i_cmd.reject) begin
                r_rejected <= 1'b1;
            end
            if (i_cmd.stop) begin
                r_rec <= 1'b0;
                if (r_count != '0) begin
                    r_ready <= 1'b1;
                    r_phase <= '0;
                end
            end
            if (i_cmd.mul) begin
                r_played <= 1'b1;
                r_phase  <= r_phase + PW'(spd_eff);
            end
            if (i_cmd.wrap_sub) begin
                r_phase <= r_phase - span;
            end
        end
    end

endmodule

`default_nettype wire
